// ===== sv/fpa_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fpa_pkg
// Shared types and constants of the fixed-partition allocator.
// ----------------------------------------------------------------------------
package fpa_pkg;

	localparam int NUM_BLOCKS_DEF = 16;
	localparam int SIZE_BITS_DEF  = 16;

	localparam int MODE_W  = 2;
	localparam int ENTRY_W = 4;
	localparam int VALUE_W = 16;
	localparam int BLOCK_W = 4;

	localparam int POLICY_W = 2;
	localparam int COUNT_W  = 5;
	localparam int CFG_W    = 5;
	localparam int CFG_IDX_W = 1;

	localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_ALLOC = 2'd1;
	localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

	localparam logic [POLICY_W-1:0] POL_FIRST = 2'd0;
	localparam logic [POLICY_W-1:0] POL_BEST  = 2'd1;
	localparam logic [POLICY_W-1:0] POL_WORST = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_POLICY      = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT = 1'd1;

	localparam logic [COUNT_W-1:0] BLOCK_COUNT_RST = 5'd16;

	// controller to datapath
	typedef struct packed {
		logic accept;
		logic step;
		logic commit;
	} fpa_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic issue_done;
		logic pipe_busy;
	} fpa_sts_t;

endpackage
`default_nettype wire

// ===== sv/fixed_partition_allocator_core.sv =====
`default_nettype none
// load, clear and unused-mode requests: accept moves the controller to the
//   result state, and the result is registered into the output register on commit
// allocate: the scan reads min(block_count, NUM_BLOCKS) size-table entries, one
//   per cycle through one comparator, before the result state and commit
// one request at a time: the next is taken once the result is in the output register
// reset: used marks all free, policy first fit, block_count 16; size table not cleared
// ----------------------------------------------------------------------------
// fixed_partition_allocator_core
// Fixed-partition allocator with first, best and worst fit selection.
// ----------------------------------------------------------------------------
module fixed_partition_allocator_core #(
	parameter int NUM_BLOCKS = fpa_pkg::NUM_BLOCKS_DEF,
	parameter int SIZE_BITS  = fpa_pkg::SIZE_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [fpa_pkg::MODE_W-1:0]    mode,
	input  wire logic [fpa_pkg::ENTRY_W-1:0]   entry_index,
	input  wire logic [fpa_pkg::VALUE_W-1:0]   size_value,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic                               granted,
	output logic [fpa_pkg::BLOCK_W-1:0]        granted_block,
	input  wire logic                          cfg_we,
	input  wire logic [fpa_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [fpa_pkg::CFG_W-1:0]     cfg_data
);
	import fpa_pkg::*;

	fpa_cmd_t cmd;
	fpa_sts_t sts;

	fpa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.mode      (mode),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.sts       (sts)
	);

	fpa_datapath #(
		.NUM_BLOCKS (NUM_BLOCKS),
		.SIZE_BITS  (SIZE_BITS)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.mode          (mode),
		.entry_index   (entry_index),
		.size_value    (size_value),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.cmd           (cmd),
		.sts           (sts),
		.granted       (granted),
		.granted_block (granted_block)
	);

endmodule
`default_nettype wire

// ===== sv/fpa_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fpa_ctrl
// Sequencer: takes a request, runs the partition scan, hands off the result.
// ----------------------------------------------------------------------------
module fpa_ctrl (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_stall,
	input  wire logic [fpa_pkg::MODE_W-1:0] mode,
	output logic                            out_valid,
	input  wire logic                       out_stall,
	output fpa_pkg::fpa_cmd_t               cmd,
	input  wire fpa_pkg::fpa_sts_t          sts
);
	import fpa_pkg::*;

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SCAN   = 2'd1;
	localparam logic [1:0] ST_RESULT = 2'd2;

	logic [1:0] state_q;
	logic       out_valid_q;
	logic       out_free;

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || !out_stall;

	always_comb begin
		cmd.accept = in_valid && (state_q == ST_IDLE);
		cmd.step   = (state_q == ST_SCAN) && !sts.issue_done;
		cmd.commit = (state_q == ST_RESULT) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.accept) begin
						state_q <= (mode == MODE_ALLOC) ? ST_SCAN : ST_RESULT;
					end
				end
				ST_SCAN: begin
					// wait for the last read to pass the compare stage
					if (sts.issue_done && !sts.pipe_busy) begin
						state_q <= ST_RESULT;
					end
				end
				ST_RESULT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	a_commit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> out_valid)
		else $error("result not presented after commit");

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |=> in_stall)
		else $error("controller still idle after accepting a request");

	a_step_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> !cmd.commit && !cmd.accept)
		else $error("scan step overlaps another command");

endmodule
`default_nettype wire

// ===== sv/fpa_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fpa_datapath
// Size table, used marks, scan counter, fit compare and result registers.
// ----------------------------------------------------------------------------
module fpa_datapath #(
	parameter int NUM_BLOCKS = fpa_pkg::NUM_BLOCKS_DEF,
	parameter int SIZE_BITS  = fpa_pkg::SIZE_BITS_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic [fpa_pkg::MODE_W-1:0]     mode,
	input  wire logic [fpa_pkg::ENTRY_W-1:0]    entry_index,
	input  wire logic [fpa_pkg::VALUE_W-1:0]    size_value,
	input  wire logic                           cfg_we,
	input  wire logic [fpa_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [fpa_pkg::CFG_W-1:0]      cfg_data,
	input  wire fpa_pkg::fpa_cmd_t              cmd,
	output fpa_pkg::fpa_sts_t                   sts,
	output logic                                granted,
	output logic [fpa_pkg::BLOCK_W-1:0]         granted_block
);
	import fpa_pkg::*;

	localparam int IDX_W = $clog2(NUM_BLOCKS);
	localparam int CNT_W = $clog2(NUM_BLOCKS + 1);
	localparam int CMP_W = (SIZE_BITS > VALUE_W) ? SIZE_BITS : VALUE_W;

	logic [POLICY_W-1:0]  policy_q;
	logic [COUNT_W-1:0]   block_count_q;

	logic [SIZE_BITS-1:0] size_mem [NUM_BLOCKS];
	logic [NUM_BLOCKS-1:0] used_q;

	logic [MODE_W-1:0]    mode_q;
	logic [VALUE_W-1:0]   req_q;
	logic [CNT_W-1:0]     idx_q;
	logic [CNT_W-1:0]     limit;

	logic                 vld_s1;
	logic [IDX_W-1:0]     idx_s1;
	logic [SIZE_BITS-1:0] size_s1;

	logic                 found_q;
	logic [IDX_W-1:0]     best_idx_q;
	logic [SIZE_BITS-1:0] best_size_q;

	logic                 load_ok;
	logic                 fits;
	logic                 better;
	logic                 take;
	logic                 grant_now;

	logic                 granted_q;
	logic [BLOCK_W-1:0]   granted_block_q;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q      <= POL_FIRST;
			block_count_q <= BLOCK_COUNT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_POLICY:      policy_q      <= cfg_data[POLICY_W-1:0];
				CFG_BLOCK_COUNT: block_count_q <= cfg_data[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	// block count saturates at the table depth
	always_comb begin
		if (32'(block_count_q) > NUM_BLOCKS) begin
			limit = CNT_W'(NUM_BLOCKS);
		end else begin
			limit = CNT_W'(block_count_q);
		end
	end

	assign load_ok = cmd.accept && (mode == MODE_LOAD) && (32'(entry_index) < NUM_BLOCKS);

	// size table, one write port and one registered read port
	always_ff @(posedge clk) begin
		if (load_ok) begin
			size_mem[IDX_W'(entry_index)] <= SIZE_BITS'(size_value);
		end
		if (cmd.step) begin
			size_s1 <= size_mem[idx_q[IDX_W-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			mode_q <= mode;
			req_q  <= size_value;
		end
		if (cmd.step) begin
			idx_s1 <= idx_q[IDX_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q  <= '0;
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= cmd.step;
			if (cmd.accept) begin
				idx_q <= '0;
			end else if (cmd.step) begin
				idx_q <= idx_q + CNT_W'(1);
			end
		end
	end

	assign sts.issue_done = (idx_q >= limit);
	assign sts.pipe_busy  = vld_s1;

	// fit compare; ties keep the earlier (lower) index
	always_comb begin
		fits   = !used_q[idx_s1] && (CMP_W'(size_s1) >= CMP_W'(req_q));
		better = ((policy_q == POL_BEST) && (size_s1 < best_size_q)) ||
		         ((policy_q == POL_WORST) && (size_s1 > best_size_q));
		take   = vld_s1 && fits && (!found_q || better);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (cmd.accept) begin
			found_q <= 1'b0;
		end else if (take) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			best_idx_q  <= idx_s1;
			best_size_q <= size_s1;
		end
	end

	assign grant_now = (mode_q == MODE_ALLOC) && found_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
		end else if (cmd.accept && (mode == MODE_CLEAR)) begin
			used_q <= '0;
		end else if (cmd.commit && grant_now) begin
			used_q[best_idx_q] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			granted_q       <= grant_now;
			granted_block_q <= grant_now ? BLOCK_W'(best_idx_q) : '0;
		end
	end

	assign granted       = granted_q;
	assign granted_block = granted_block_q;

	a_pipe_follows_step: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> $past(cmd.step))
		else $error("compare stage valid without a read");

	a_grant_marks_used: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit && grant_now |=> used_q[$past(best_idx_q)])
		else $error("granted block not marked used");

	a_pick_fits: assert property (@(posedge clk) disable iff (!arst_n)
		found_q |-> (CMP_W'(best_size_q) >= CMP_W'(req_q)))
		else $error("picked block smaller than the request");

endmodule
`default_nettype wire

// ===== test/tb_fixed_partition_allocator_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tb_fixed_partition_allocator_core
// Self-checking bench for the fixed-partition allocator. Requests are driven
// through the valid/stall input channel. Each one is applied to a local model
// of the size table, the used marks and both registers. Results are compared
// in order against the model's predictions. Directed tests cover the fit
// policies, ties, clear, the unused mode and policy, and the block count
// extremes. Random phases at several register settings follow.
// ----------------------------------------------------------------------------
module tb_fixed_partition_allocator_core;
	import fpa_pkg::*;

	localparam logic [MODE_W-1:0]   MODE_UNUSED = 2'd3;
	localparam logic [POLICY_W-1:0] POL_UNUSED  = 2'd3;
	localparam int MAX_GAP   = 12;
	localparam int LONG_HOLD = 300;
	localparam int DRAIN_CYCLES = 40;

	typedef struct packed {
		logic               granted;
		logic [BLOCK_W-1:0] blk_index;
	} grant_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b1;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic [MODE_W-1:0]    mode = MODE_LOAD;
	logic [ENTRY_W-1:0]   entry_index = '0;
	logic [VALUE_W-1:0]   size_value = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic                 granted;
	logic [BLOCK_W-1:0]   granted_block;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_POLICY;
	logic [CFG_W-1:0]     cfg_data = '0;

	// allocator model state
	logic [VALUE_W-1:0]  part_size [NUM_BLOCKS_DEF];
	bit                  part_used [NUM_BLOCKS_DEF];
	logic [POLICY_W-1:0] cur_policy = POL_FIRST;
	logic [COUNT_W-1:0]  cur_count = BLOCK_COUNT_RST;

	grant_t pending_grants [$];
	int     fail_count = 0;
	bit     no_idle = 1'b0;
	bit     hold_off_pending = 1'b0;

	fixed_partition_allocator_core i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.mode          (mode),
		.entry_index   (entry_index),
		.size_value    (size_value),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.granted       (granted),
		.granted_block (granted_block),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void apply_request(input logic [MODE_W-1:0] m,
			input logic [ENTRY_W-1:0] idx, input logic [VALUE_W-1:0] val);
		grant_t res;
		int     limit;
		bit     found;
		int     pick;
		res = '0;
		found = 1'b0;
		pick = 0;
		limit = (cur_count > NUM_BLOCKS_DEF) ? NUM_BLOCKS_DEF : int'(cur_count);
		case (m)
			MODE_LOAD: begin
				part_size[idx] = val;
			end
			MODE_ALLOC: begin
				// ties keep the lower index since only a strict compare moves the pick
				for (int k = 0; k < limit; k++) begin
					if (!part_used[k] && part_size[k] >= val) begin
						if (!found) begin
							found = 1'b1;
							pick = k;
						end else if (cur_policy == POL_BEST && part_size[k] < part_size[pick]) begin
							pick = k;
						end else if (cur_policy == POL_WORST && part_size[k] > part_size[pick]) begin
							pick = k;
						end
					end
				end
				if (found) begin
					part_used[pick] = 1'b1;
					res.granted = 1'b1;
					res.blk_index = pick[BLOCK_W-1:0];
				end
			end
			MODE_CLEAR: begin
				foreach (part_used[k])
					part_used[k] = 1'b0;
			end
			default: ;
		endcase
		pending_grants.push_back(res);
	endfunction

	task automatic send_request(input logic [MODE_W-1:0] m, input logic [ENTRY_W-1:0] idx,
			input logic [VALUE_W-1:0] val);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
		@(negedge clk);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		mode <= m;
		entry_index <= idx;
		size_value <= val;
		do @(posedge clk); while (in_stall);
		apply_request(m, idx, val);
	endtask

	task automatic wait_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_grants.size() != 0)
			@(posedge clk);
		repeat (3) @(negedge clk);
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_POLICY)
			cur_policy = data[POLICY_W-1:0];
		else
			cur_count = data;
	endtask

	function automatic logic [VALUE_W-1:0] pick_size();
		int r;
		r = $urandom_range(0, 9);
		// coarse steps give plenty of size ties
		if (r < 5)
			return VALUE_W'($urandom_range(0, 15) * 64);
		else if (r < 8)
			return VALUE_W'($urandom_range(0, 2000));
		else
			return VALUE_W'($urandom_range(0, 65535));
	endfunction

	task automatic send_random_request();
		int r;
		r = $urandom_range(0, 99);
		if (r < 12)
			send_request(MODE_LOAD, ENTRY_W'($urandom_range(0, 15)), pick_size());
		else if (r < 80)
			send_request(MODE_ALLOC, ENTRY_W'($urandom_range(0, 15)), pick_size());
		else if (r < 92)
			send_request(MODE_CLEAR, ENTRY_W'($urandom_range(0, 15)), VALUE_W'($urandom));
		else if (r < 96)
			send_request(MODE_UNUSED, ENTRY_W'($urandom_range(0, 15)), VALUE_W'($urandom));
		else
			send_request(MODE_ALLOC, ENTRY_W'($urandom_range(0, 15)), VALUE_W'($urandom));
	endtask

	// every entry is written before any allocate can search it
	task automatic test_load_table();
		logic [VALUE_W-1:0] sz;
		for (int k = 0; k < NUM_BLOCKS_DEF; k++) begin
			if (k == 0)
				sz = '0;
			else if (k == NUM_BLOCKS_DEF - 1)
				sz = '1;
			else
				sz = VALUE_W'(((k * 2) % 7) * 100 + 50);
			send_request(MODE_LOAD, ENTRY_W'(k), sz);
		end
	endtask

	task automatic test_first_fit();
		send_request(MODE_ALLOC, '0, '0);
		send_request(MODE_ALLOC, '1, '1);
		send_request(MODE_ALLOC, '0, '1);
		send_request(MODE_ALLOC, '0, 16'd600);
		send_request(MODE_UNUSED, '1, '1);
		send_request(MODE_CLEAR, '0, '0);
	endtask

	task automatic test_policies_and_count();
		wait_idle();
		write_register(CFG_POLICY, {3'b111, POL_BEST});
		send_request(MODE_ALLOC, '0, 16'd240);
		wait_idle();
		write_register(CFG_POLICY, {3'b000, POL_WORST});
		send_request(MODE_ALLOC, '0, 16'd1);
		wait_idle();
		write_register(CFG_POLICY, {3'b000, POL_UNUSED});
		send_request(MODE_ALLOC, '0, 16'd1);
		wait_idle();
		write_register(CFG_BLOCK_COUNT, 5'd0);
		send_request(MODE_ALLOC, '0, '0);
		wait_idle();
		write_register(CFG_BLOCK_COUNT, 5'd31);
		send_request(MODE_ALLOC, '0, '0);
		wait_idle();
		write_register(CFG_BLOCK_COUNT, 5'd1);
		send_request(MODE_ALLOC, '0, '0);
		send_request(MODE_CLEAR, '0, '0);
		send_request(MODE_ALLOC, '0, '0);
		wait_idle();
		write_register(CFG_POLICY, {3'b000, POL_FIRST});
		write_register(CFG_BLOCK_COUNT, BLOCK_COUNT_RST);
	endtask

	task automatic test_random_phases();
		logic [POLICY_W-1:0] pol [6] = '{POL_FIRST, POL_BEST, POL_WORST, POL_UNUSED,
			POL_BEST, POL_WORST};
		logic [COUNT_W-1:0]  cnt [6] = '{5'd16, 5'd1, 5'd31, 5'd0, 5'd17, 5'd16};
		for (int p = 0; p < 6; p++) begin
			wait_idle();
			write_register(CFG_POLICY, {3'($urandom_range(0, 7)), pol[p]});
			write_register(CFG_BLOCK_COUNT,
				(p == 5) ? COUNT_W'($urandom_range(2, 15)) : cnt[p]);
			repeat (95) send_random_request();
		end
	endtask

	task automatic test_back_to_back();
		wait_idle();
		write_register(CFG_POLICY, {3'b000, POL_BEST});
		write_register(CFG_BLOCK_COUNT, BLOCK_COUNT_RST);
		no_idle = 1'b1;
		repeat (40) send_random_request();
		no_idle = 1'b0;
	endtask

	// receiver sits on its stall while requests keep coming
	task automatic test_backpressure();
		hold_off_pending = 1'b1;
		no_idle = 1'b1;
		repeat (15) send_random_request();
		no_idle = 1'b0;
	endtask

	initial begin : receiver
		int wait_n;
		@(posedge arst_n);
		forever begin
			if (hold_off_pending) begin
				@(negedge clk);
				out_stall <= 1'b1;
				repeat (LONG_HOLD) @(negedge clk);
				hold_off_pending = 1'b0;
			end
			wait_n = no_idle ? 0 : $urandom_range(0, MAX_GAP);
			if (wait_n != 0) begin
				@(negedge clk);
				out_stall <= 1'b1;
				repeat (wait_n - 1) @(negedge clk);
			end
			@(negedge clk);
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
		end
	end

	always @(posedge clk) begin : result_check
		grant_t exp_r;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_grants.size() == 0) begin
				$display("%0t: unexpected result granted=%0d block=%0d", $time, granted,
					granted_block);
				fail_count++;
			end else begin
				exp_r = pending_grants.pop_front();
				if (granted !== exp_r.granted) begin
					$display("%0t: granted mismatch expected %0d actual %0d", $time,
						exp_r.granted, granted);
					fail_count++;
				end
				if (granted_block !== exp_r.blk_index) begin
					$display("%0t: granted_block mismatch expected %0d actual %0d", $time,
						exp_r.blk_index, granted_block);
					fail_count++;
				end
			end
		end
	end

	initial begin
		// falling edge after every process has started, so the async reset fires
		arst_n <= 1'b0;
		foreach (part_used[k])
			part_used[k] = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_load_table();
		test_first_fit();
		test_policies_and_count();
		test_random_phases();
		test_back_to_back();
		test_backpressure();
		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending_grants.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	initial begin
		#3_000_000;
		$display("TEST FAILED");
		$finish;
	end

endmodule
`default_nettype wire
